// ===== design/fcse_pkg.sv =====
package fcse_pkg;

    // Table geometry and walk limits.
    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_EXTENTS   = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int STEP_W        = IDX_W + 1;
    localparam int EXT_W         = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

    // Link value that closes a chain.
    localparam logic [31:0] CHAIN_END = 32'h0FFF_FFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_RESERVED_SECTORS    = 2'd0;
    localparam logic [1:0] REG_FAT_COPIES          = 2'd1;
    localparam logic [1:0] REG_FAT_SIZE_SECTORS    = 2'd2;
    localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd3;

    // Input word kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_WALK = 1'b1;

    typedef enum logic [1:0] {
        WALK_OK      = 2'd0,
        WALK_EMPTY   = 2'd1,
        WALK_OUTSIDE = 2'd2,
        WALK_LIMIT   = 2'd3
    } walk_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_BASE,
        ST_MAP,
        ST_MERGE,
        ST_LINK
    } walk_state_t;

    // Volume geometry as held by the configuration registers.
    typedef struct packed {
        logic [15:0] reserved_sectors;
        logic [7:0]  fat_copies;
        logic [31:0] fat_size_sectors;
        logic [7:0]  sectors_per_cluster;
    } volume_cfg_t;

endpackage

// ===== design/fcse_table_ram.sv =====
module fcse_table_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fcse_walker.sv =====
module fcse_walker
    import fcse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  volume_cfg_t      cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [11:0]      s_entry_index,
    input  logic [31:0]      s_entry_value,
    input  logic [31:0]      s_start_cluster,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_first_sector,
    output logic [31:0]      m_last_sector,
    output logic             m_final_extent,
    output logic [1:0]       m_walk_status,
    output logic             ram_wr_en,
    output logic [IDX_W-1:0] ram_wr_addr,
    output logic [31:0]      ram_wr_data,
    output logic             ram_rd_en,
    output logic [IDX_W-1:0] ram_rd_addr,
    input  logic [31:0]      ram_rd_data
);

    walk_state_t       state_reg, state_next;
    logic [31:0]       cluster_reg, cluster_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       sector_reg, sector_next;
    logic [31:0]       run_first_reg, run_first_next;
    logic [31:0]       run_last_reg, run_last_next;
    logic              have_run_reg, have_run_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [EXT_W-1:0]  runs_reg, runs_next;

    logic              m_valid_reg;
    logic [31:0]       m_first_reg, m_last_reg;
    logic              m_final_reg;
    walk_status_t      m_status_reg;

    logic              out_free;
    logic              out_load;
    logic [31:0]       out_first, out_last;
    logic              out_final;
    walk_status_t      out_status;

    logic              accept;
    logic              cluster_in_table;
    logic [39:0]       map_product;
    logic [39:0]       base_product;
    logic [31:0]       map_sector;
    logic [31:0]       sector_last;
    logic              contiguous;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // Sector arithmetic, all modulo 2^32.
    assign base_product     = 40'(cfg.fat_copies) * 40'(cfg.fat_size_sectors);
    assign map_product      = 40'(cluster_reg - 32'd2) * 40'(cfg.sectors_per_cluster);
    assign map_sector       = base_reg + map_product[31:0];
    assign sector_last      = sector_reg + 32'(cfg.sectors_per_cluster) - 32'd1;
    assign contiguous       = have_run_reg && (sector_reg == run_last_reg + 32'd1);
    assign cluster_in_table = cluster_reg < 32'(TABLE_ENTRIES);

    // Load words write the table straight from the input.
    assign ram_wr_en   = accept && (s_kind == KIND_LOAD)
                         && (32'(s_entry_index) < 32'(TABLE_ENTRIES));
    assign ram_wr_addr = IDX_W'(32'(s_entry_index));
    assign ram_wr_data = s_entry_value;
    assign ram_rd_addr = cluster_reg[IDX_W-1:0];

    // Sequencer: one table read per chain link, then merge and follow.
    always_comb begin
        state_next     = state_reg;
        cluster_next   = cluster_reg;
        base_next      = base_reg;
        sector_next    = sector_reg;
        run_first_next = run_first_reg;
        run_last_next  = run_last_reg;
        have_run_next  = have_run_reg;
        steps_next     = steps_reg;
        runs_next      = runs_reg;
        s_ready        = 1'b0;
        ram_rd_en      = 1'b0;
        out_load       = 1'b0;
        out_first      = run_first_reg;
        out_last       = run_last_reg;
        out_final      = 1'b1;
        out_status     = WALK_OK;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_kind == KIND_WALK)) begin
                    cluster_next  = s_start_cluster;
                    have_run_next = 1'b0;
                    steps_next    = '0;
                    runs_next     = '0;
                    state_next    = (s_start_cluster < 32'd2) ? ST_EMPTY : ST_BASE;
                end
            end
            ST_EMPTY: begin
                out_first  = 32'd0;
                out_last   = 32'd0;
                out_status = WALK_EMPTY;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BASE: begin
                base_next  = 32'(cfg.reserved_sectors) + base_product[31:0];
                state_next = ST_MAP;
            end
            ST_MAP: begin
                // A chain this long has a loop in it.
                if (steps_reg == STEP_W'(TABLE_ENTRIES)) begin
                    out_status = WALK_LIMIT;
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    sector_next = map_sector;
                    ram_rd_en   = cluster_in_table;
                    state_next  = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (contiguous) begin
                    run_last_next = sector_last;
                    steps_next    = steps_reg + 1'b1;
                    state_next    = ST_LINK;
                end else if (!have_run_reg) begin
                    run_first_next = sector_reg;
                    run_last_next  = sector_last;
                    have_run_next  = 1'b1;
                    steps_next     = steps_reg + 1'b1;
                    state_next     = ST_LINK;
                end else if (32'(runs_reg) >= 32'(MAX_EXTENTS - 1)) begin
                    // No room for another run: close the walk on this one.
                    out_status = WALK_LIMIT;
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    out_final = 1'b0;
                    if (out_free) begin
                        out_load       = 1'b1;
                        run_first_next = sector_reg;
                        run_last_next  = sector_last;
                        runs_next      = runs_reg + 1'b1;
                        steps_next     = steps_reg + 1'b1;
                        state_next     = ST_LINK;
                    end
                end
            end
            ST_LINK: begin
                if (!cluster_in_table) begin
                    out_status = WALK_OUTSIDE;
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (ram_rd_data == CHAIN_END) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cluster_next = ram_rd_data;
                    state_next   = ST_MAP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            have_run_reg <= 1'b0;
            steps_reg    <= '0;
            runs_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            have_run_reg <= have_run_next;
            steps_reg    <= steps_next;
            runs_reg     <= runs_next;
        end
    end

    // Walk datapath.
    always_ff @(posedge aclk) begin
        cluster_reg   <= cluster_next;
        base_reg      <= base_next;
        sector_reg    <= sector_next;
        run_first_reg <= run_first_next;
        run_last_reg  <= run_last_next;
    end

    // Output register: one result word waits here for the consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_first_reg  <= out_first;
            m_last_reg   <= out_last;
            m_final_reg  <= out_final;
            m_status_reg <= out_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_sector = m_first_reg;
    assign m_last_sector  = m_last_reg;
    assign m_final_extent = m_final_reg;
    assign m_walk_status  = m_status_reg;

endmodule

// ===== design/fat_chain_to_sector_extents.sv =====
// FAT32 cluster chain walker. Load words (kind 0) write one allocation table entry. A walk
// word (kind 1) follows the chain from its start cluster through the internal table and
// returns one result word per run of contiguous sectors, the last one flagged final with a
// status: ok, empty chain (start below 2), cluster outside the table, or extent/step limit.
// The input is taken only between walks. A walk is accepted, then forms the table base
// sector, then handles each cluster visited by address and table read, run merge and link
// follow; an empty chain goes from acceptance straight to its result word. Each result
// word waits in an output register, and the walk pauses when a second word is due before
// the first is taken. Configuration writes take effect at once and belong between walks.
// Table entries are undefined until loaded.
module fat_chain_to_sector_extents
    import fcse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [11:0] s_entry_index,
    input  logic [31:0] s_entry_value,
    input  logic [31:0] s_start_cluster,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_first_sector,
    output logic [31:0] m_last_sector,
    output logic        m_final_extent,
    output logic [1:0]  m_walk_status
);

    volume_cfg_t      cfg_reg;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [31:0]      ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [31:0]      ram_rd_data;

    // Volume geometry registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reserved_sectors    <= 16'd32;
            cfg_reg.fat_copies          <= 8'd2;
            cfg_reg.fat_size_sectors    <= 32'd0;
            cfg_reg.sectors_per_cluster <= 8'd8;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RESERVED_SECTORS:    cfg_reg.reserved_sectors    <= cfg_wdata[15:0];
                REG_FAT_COPIES:          cfg_reg.fat_copies          <= cfg_wdata[7:0];
                REG_FAT_SIZE_SECTORS:    cfg_reg.fat_size_sectors    <= cfg_wdata;
                REG_SECTORS_PER_CLUSTER: cfg_reg.sectors_per_cluster <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Allocation table.
    fcse_table_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (32)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Chain sequencer and extent builder.
    fcse_walker u_walker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_entry_index   (s_entry_index),
        .s_entry_value   (s_entry_value),
        .s_start_cluster (s_start_cluster),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_sector  (m_first_sector),
        .m_last_sector   (m_last_sector),
        .m_final_extent  (m_final_extent),
        .m_walk_status   (m_walk_status),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .ram_rd_en       (ram_rd_en),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data)
    );

endmodule
